/* hw/rtl/pps_pkg.sv */
// ----------------------------------------------------------------------------
// pps_pkg
// shared types, constants and sentence helpers for the pps / gprmc generator
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int COUNT_BITS = 20;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam int PPS_W      = 4;
    localparam int HOUR_W     = 5;
    localparam int MIN_W      = 6;
    localparam int SEC_W      = 6;
    localparam int IDX_W      = 7;

    localparam int SENT_LEN  = 67;
    localparam int XOR_FIRST = 1;
    localparam int XOR_LAST  = 61;

    localparam logic [IDX_W-1:0] IDX_HOUR_T = 7'd7;
    localparam logic [IDX_W-1:0] IDX_HOUR_O = 7'd8;
    localparam logic [IDX_W-1:0] IDX_MIN_T  = 7'd9;
    localparam logic [IDX_W-1:0] IDX_MIN_O  = 7'd10;
    localparam logic [IDX_W-1:0] IDX_SEC_T  = 7'd11;
    localparam logic [IDX_W-1:0] IDX_SEC_O  = 7'd12;
    localparam logic [IDX_W-1:0] IDX_CSUM_H = 7'd63;
    localparam logic [IDX_W-1:0] IDX_CSUM_L = 7'd64;
    localparam logic [IDX_W-1:0] IDX_LAST   = 7'(SENT_LEN - 1);

    localparam logic [COUNT_BITS-1:0] PERIOD_RST = COUNT_BITS'(100000);
    localparam logic [COUNT_BITS-1:0] WIDTH_RST  = COUNT_BITS'(1000);
    localparam logic [PPS_W-1:0]      PPS_RST    = 4'd10;
    localparam logic [HOUR_W-1:0]     HOUR_RST   = 5'd12;
    localparam logic [HOUR_W-1:0]     HOURS_DAY  = 5'd24;
    localparam logic [MIN_W-1:0]      MINS_HOUR  = 6'd60;
    localparam logic [SEC_W-1:0]      SECS_MIN   = 6'd60;

    // register index codes (paddr[3:2])
    localparam logic [1:0] REG_PERIOD = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_PPS    = 2'd2;

    localparam logic [SENT_LEN*8-1:0] SENT_TPL =
        "$GPRMC,000000.00,A,3000.0000,N,12000.0000,E,0.0,0.0,010124,,,A*00\r\n";

    typedef struct packed {
        logic [COUNT_BITS-1:0] period;
        logic [COUNT_BITS-1:0] width;
        logic [PPS_W-1:0]      pps;
    } t_pps_cfg;

    // tens digit of a value below 64
    function automatic logic [2:0] tens_of(input logic [5:0] v);
        logic [2:0] t;
        if (v >= 6'd60)      t = 3'd6;
        else if (v >= 6'd50) t = 3'd5;
        else if (v >= 6'd40) t = 3'd4;
        else if (v >= 6'd30) t = 3'd3;
        else if (v >= 6'd20) t = 3'd2;
        else if (v >= 6'd10) t = 3'd1;
        else                 t = 3'd0;
        return t;
    endfunction

    function automatic logic [7:0] dec_tens(input logic [5:0] v);
        return 8'h30 + {5'd0, tens_of(v)};
    endfunction

    function automatic logic [7:0] dec_ones(input logic [5:0] v);
        logic [5:0] t10;
        t10 = 6'({3'd0, tens_of(v)} * 6'd10);
        return 8'h30 + {2'd0, v - t10};
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        return (v < 4'd10) ? (8'd48 + {4'd0, v}) : (8'd55 + {4'd0, v});
    endfunction

    function automatic logic [7:0] tpl_byte(input logic [IDX_W-1:0] idx);
        logic [7:0] b;
        if (int'(idx) < SENT_LEN) b = SENT_TPL[(SENT_LEN - 1 - int'(idx)) * 8 +: 8];
        else                      b = 8'd0;
        return b;
    endfunction

endpackage

/* hw/rtl/pps_in_if.sv */
// ----------------------------------------------------------------------------
// pps_in_if
// tick channel: one item per timebase tick, carrying the transmitter ready flag
// ----------------------------------------------------------------------------
interface pps_in_if;
    logic valid;
    logic ready;
    logic byte_ready;

    modport source (output valid, output byte_ready, input ready);
    modport sink   (input valid, input byte_ready, output ready);
endinterface

/* hw/rtl/pps_out_if.sv */
// ----------------------------------------------------------------------------
// pps_out_if
// result channel: pulse levels, running clock and at most one sentence byte per item
// ----------------------------------------------------------------------------
interface pps_out_if;
    logic       valid;
    logic       ready;
    logic       pulse_fast;
    logic       pulse_slow;
    logic [4:0] clock_hour;
    logic [5:0] clock_minute;
    logic [5:0] clock_second;
    logic [7:0] sentence_byte;
    logic       sentence_valid;
    logic       sentence_last;

    modport source (output valid, output pulse_fast, output pulse_slow,
                    output clock_hour, output clock_minute, output clock_second,
                    output sentence_byte, output sentence_valid, output sentence_last,
                    input ready);
    modport sink   (input valid, input pulse_fast, input pulse_slow,
                    input clock_hour, input clock_minute, input clock_second,
                    input sentence_byte, input sentence_valid, input sentence_last,
                    output ready);
endinterface

/* hw/rtl/pps_cfg_regs.sv */
// ----------------------------------------------------------------------------
// pps_cfg_regs
// apb register file: fast period, pulse width and pulses per second
// ----------------------------------------------------------------------------
module pps_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pps_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [pps_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [pps_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output pps_pkg::t_pps_cfg              o_cfg
);
    import pps_pkg::*;

    t_pps_cfg r_cfg;
    t_pps_cfg n_cfg;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (paddr[3:2])
                REG_PERIOD: n_cfg.period = pwdata[COUNT_BITS-1:0];
                REG_WIDTH:  n_cfg.width  = pwdata[COUNT_BITS-1:0];
                REG_PPS:    n_cfg.pps    = pwdata[PPS_W-1:0];
                default:    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period <= PERIOD_RST;
            r_cfg.width  <= WIDTH_RST;
            r_cfg.pps    <= PPS_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_PERIOD: prdata = {{(CFG_DATA_W-COUNT_BITS){1'b0}}, r_cfg.period};
            REG_WIDTH:  prdata = {{(CFG_DATA_W-COUNT_BITS){1'b0}}, r_cfg.width};
            REG_PPS:    prdata = {{(CFG_DATA_W-PPS_W){1'b0}}, r_cfg.pps};
            default:    prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

/* hw/rtl/pps_pulse_and_gprmc_time_generator.sv */
// ----------------------------------------------------------------------------
// pps_pulse_and_gprmc_time_generator
// fast/slow pulse timing, hh:mm:ss clock and gprmc sentence byte stream
// ----------------------------------------------------------------------------
// Each input item is one timebase tick; the block can take one tick in every
// clock cycle and returns exactly one result item per tick, in the cycle
// after the tick is accepted. The input is ready whenever the single result
// register is empty or is being taken in the same cycle, so the sustained
// rate is one item per cycle and is set by that result register alone.
// Configuration is written through the apb port at byte addresses 0, 4, 8.
module pps_pulse_and_gprmc_time_generator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pps_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [pps_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [pps_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    pps_in_if.sink                         i_tick,
    pps_out_if.source                      o_res
);
    import pps_pkg::*;

    t_pps_cfg w_cfg;

    pps_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // timing and sentence state
    logic [COUNT_BITS-1:0] r_phase,   n_phase;
    logic                  r_high,    n_high;
    logic [PPS_W-1:0]      r_fcnt,    n_fcnt;
    logic                  r_slow,    n_slow;
    logic [HOUR_W-1:0]     r_hour,    n_hour;
    logic [MIN_W-1:0]      r_min,     n_min;
    logic [SEC_W-1:0]      r_sec,     n_sec;
    logic                  r_req,     n_req;
    logic                  r_sending, n_sending;
    logic [IDX_W-1:0]      r_idx,     n_idx;
    logic [7:0]            r_xor,     n_xor;
    logic [HOUR_W-1:0]     r_lat_h,   n_lat_h;
    logic [MIN_W-1:0]      r_lat_m,   n_lat_m;
    logic [SEC_W-1:0]      r_lat_s,   n_lat_s;

    // result register
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_byte,      n_byte;
    logic       r_bvalid,    n_bvalid;
    logic       r_blast,     n_blast;

    logic                  w_in_acc;
    logic [COUNT_BITS-1:0] w_len;
    logic [COUNT_BITS-1:0] w_phase_inc;
    logic [PPS_W-1:0]      w_fcnt_inc;
    logic [7:0]            w_char;

    assign i_tick.ready = !r_out_valid || o_res.ready;
    assign w_in_acc     = i_tick.valid && i_tick.ready;

    always_comb begin
        if (r_high)
            w_len = (w_cfg.width == '0) ? COUNT_BITS'(1) : w_cfg.width;
        else
            w_len = (w_cfg.width < w_cfg.period) ? (w_cfg.period - w_cfg.width)
                                                 : COUNT_BITS'(1);
    end

    assign w_phase_inc = r_phase + COUNT_BITS'(1);
    assign w_fcnt_inc  = r_fcnt + PPS_W'(1);

    always_comb begin
        n_phase     = r_phase;
        n_high      = r_high;
        n_fcnt      = r_fcnt;
        n_slow      = r_slow;
        n_hour      = r_hour;
        n_min       = r_min;
        n_sec       = r_sec;
        n_req       = r_req;
        n_sending   = r_sending;
        n_idx       = r_idx;
        n_xor       = r_xor;
        n_lat_h     = r_lat_h;
        n_lat_m     = r_lat_m;
        n_lat_s     = r_lat_s;
        n_byte      = 8'd0;
        n_bvalid    = 1'b0;
        n_blast     = 1'b0;
        w_char      = 8'd0;
        n_out_valid = r_out_valid && !o_res.ready;

        if (w_in_acc) begin
            n_out_valid = 1'b1;

            // phase timing
            if (w_phase_inc >= w_len || w_phase_inc == '0) begin
                n_phase = '0;
                n_high  = !r_high;
                if (!r_high) begin
                    if (w_fcnt_inc >= w_cfg.pps) begin
                        n_slow = 1'b1;
                        n_fcnt = '0;
                        n_req  = 1'b1;
                        if (r_sec + SEC_W'(1) >= SECS_MIN) begin
                            n_sec = '0;
                            if (r_min + MIN_W'(1) >= MINS_HOUR) begin
                                n_min = '0;
                                if (r_hour + HOUR_W'(1) >= HOURS_DAY) n_hour = '0;
                                else                                  n_hour = r_hour + HOUR_W'(1);
                            end else begin
                                n_min = r_min + MIN_W'(1);
                            end
                        end else begin
                            n_sec = r_sec + SEC_W'(1);
                        end
                    end else begin
                        n_fcnt = w_fcnt_inc;
                        if (w_fcnt_inc == PPS_W'(1)) n_slow = 1'b0;
                    end
                end
            end else begin
                n_phase = w_phase_inc;
            end

            // sentence start
            if (!r_sending && n_req) begin
                n_req     = 1'b0;
                n_sending = 1'b1;
                n_idx     = '0;
                n_xor     = '0;
                n_lat_h   = n_hour;
                n_lat_m   = n_min;
                n_lat_s   = n_sec;
            end

            // byte out
            if (n_sending && i_tick.byte_ready) begin
                case (n_idx)
                    IDX_HOUR_T: w_char = dec_tens({1'b0, n_lat_h});
                    IDX_HOUR_O: w_char = dec_ones({1'b0, n_lat_h});
                    IDX_MIN_T:  w_char = dec_tens(n_lat_m);
                    IDX_MIN_O:  w_char = dec_ones(n_lat_m);
                    IDX_SEC_T:  w_char = dec_tens(n_lat_s);
                    IDX_SEC_O:  w_char = dec_ones(n_lat_s);
                    IDX_CSUM_H: w_char = hex_digit(n_xor[7:4]);
                    IDX_CSUM_L: w_char = hex_digit(n_xor[3:0]);
                    default:    w_char = tpl_byte(n_idx);
                endcase
                n_byte   = w_char;
                n_bvalid = 1'b1;
                if (n_idx >= IDX_W'(XOR_FIRST) && n_idx <= IDX_W'(XOR_LAST))
                    n_xor = n_xor ^ w_char;
                if (n_idx >= IDX_LAST) begin
                    n_blast   = 1'b1;
                    n_sending = 1'b0;
                    n_idx     = '0;
                end else begin
                    n_idx = n_idx + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_high      <= 1'b0;
            r_fcnt      <= '0;
            r_slow      <= 1'b0;
            r_hour      <= HOUR_RST;
            r_min       <= '0;
            r_sec       <= '0;
            r_req       <= 1'b0;
            r_sending   <= 1'b0;
            r_idx       <= '0;
            r_xor       <= '0;
            r_lat_h     <= '0;
            r_lat_m     <= '0;
            r_lat_s     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_high      <= n_high;
            r_fcnt      <= n_fcnt;
            r_slow      <= n_slow;
            r_hour      <= n_hour;
            r_min       <= n_min;
            r_sec       <= n_sec;
            r_req       <= n_req;
            r_sending   <= n_sending;
            r_idx       <= n_idx;
            r_xor       <= n_xor;
            r_lat_h     <= n_lat_h;
            r_lat_m     <= n_lat_m;
            r_lat_s     <= n_lat_s;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_byte   <= n_byte;
            r_bvalid <= n_bvalid;
            r_blast  <= n_blast;
        end
    end

    // pulse levels and clock are the state itself after the last tick
    assign o_res.valid          = r_out_valid;
    assign o_res.pulse_fast     = r_high;
    assign o_res.pulse_slow     = r_slow;
    assign o_res.clock_hour     = r_hour;
    assign o_res.clock_minute   = r_min;
    assign o_res.clock_second   = r_sec;
    assign o_res.sentence_byte  = r_byte;
    assign o_res.sentence_valid = r_bvalid;
    assign o_res.sentence_last  = r_blast;

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hour < HOURS_DAY && r_min < MINS_HOUR && r_sec < SECS_MIN)
        else $error("clock out of range");

    a_fcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcnt != 4'hF)
        else $error("fast pulse count out of range");

    a_idle_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sending |-> r_idx == '0)
        else $error("byte index not cleared while idle");

    a_acc_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_out_valid)
        else $error("accepted tick produced no result");

    a_last_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && n_blast) |=> (r_bvalid && r_byte == 8'h0A && !r_sending))
        else $error("sentence end mismatch");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the pps pulse and gprmc time generator
// ----------------------------------------------------------------------------
// Ticks are fed from a queue through a clocked driver with random gaps while
// the result side stalls at random. A cycle model of the pulse timing, the
// running clock and the sentence stream predicts every result item, and a
// clocked monitor compares each result with the oldest prediction field by
// field. Registers are rewritten over the apb port only while nothing is in
// flight, through a directed opening and a series of random settings.
// ----------------------------------------------------------------------------
module tb_top;
    import pps_pkg::*;

    localparam string GPRMC_FRAME =
        "$GPRMC,000000.00,A,3000.0000,N,12000.0000,E,0.0,0.0,010124,,,A*00\r\n";

    typedef struct packed {
        logic       pulse_fast;
        logic       pulse_slow;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [7:0] sbyte;
        logic       svalid;
        logic       slast;
    } t_tick_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    pps_in_if  tick_if ();
    pps_out_if out_if ();

    pps_pulse_and_gprmc_time_generator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_tick  (tick_if),
        .o_res   (out_if)
    );

    // model state
    logic [COUNT_BITS-1:0] m_period, m_width, phase_cnt;
    logic [PPS_W-1:0]      m_pps, fast_cnt;
    logic                  high_phase, slow_lvl, req_pending, tx_busy;
    logic [HOUR_W-1:0]     hh, lat_h;
    logic [MIN_W-1:0]      mm, lat_m;
    logic [SEC_W-1:0]      ss, lat_s;
    logic [IDX_W-1:0]      char_idx;
    logic [7:0]            csum;

    logic                  pending_ticks[$];
    t_tick_result          predicted_outputs[$];
    int unsigned           ticks_issued, ticks_taken, gap_left, stall_left;
    int unsigned           error_count, seconds_ticked, bytes_sent, sentences_done;
    int unsigned           cfg_writes;
    bit                    no_idle;

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("mismatch on %s at tick %0d: got 0x%0h, expected 0x%0h",
                 what, ticks_taken, got, want);
        error_count++;
    endtask

    function automatic t_tick_result next_tick(input logic rdy);
        t_tick_result          r;
        logic [COUNT_BITS-1:0] span;
        logic [7:0]            ch;
        logic [3:0]            nib;
        r = '0;
        if (high_phase) span = (m_width == '0) ? COUNT_BITS'(1) : m_width;
        else            span = (m_width < m_period) ? m_period - m_width : COUNT_BITS'(1);
        phase_cnt = phase_cnt + 1'b1;
        if (phase_cnt >= span || phase_cnt == '0) begin
            phase_cnt  = '0;
            high_phase = ~high_phase;
            if (high_phase) begin
                fast_cnt = fast_cnt + 1'b1;
                if (fast_cnt >= m_pps) begin
                    slow_lvl    = 1'b1;
                    fast_cnt    = '0;
                    req_pending = 1'b1;
                    seconds_ticked++;
                    if (ss == 6'd59) begin
                        ss = '0;
                        if (mm == 6'd59) begin
                            mm = '0;
                            hh = (hh == 5'd23) ? 5'd0 : hh + 1'b1;
                        end else begin
                            mm = mm + 1'b1;
                        end
                    end else begin
                        ss = ss + 1'b1;
                    end
                end else if (fast_cnt == 4'd1) begin
                    slow_lvl = 1'b0;
                end
            end
        end
        if (!tx_busy && req_pending) begin
            req_pending = 1'b0;
            tx_busy     = 1'b1;
            char_idx    = '0;
            csum        = '0;
            lat_h       = hh;
            lat_m       = mm;
            lat_s       = ss;
        end
        if (tx_busy && rdy) begin
            case (int'(char_idx))
                7:  ch = 8'(48 + int'(lat_h) / 10);
                8:  ch = 8'(48 + int'(lat_h) % 10);
                9:  ch = 8'(48 + int'(lat_m) / 10);
                10: ch = 8'(48 + int'(lat_m) % 10);
                11: ch = 8'(48 + int'(lat_s) / 10);
                12: ch = 8'(48 + int'(lat_s) % 10);
                63, 64: begin
                    nib = (char_idx == 7'd63) ? csum[7:4] : csum[3:0];
                    ch  = (nib < 4'd10) ? 8'(48 + nib) : 8'(55 + nib);
                end
                default: ch = GPRMC_FRAME.getc(int'(char_idx));
            endcase
            if (char_idx >= 7'd1 && char_idx <= 7'd61) csum = csum ^ ch;
            r.sbyte  = ch;
            r.svalid = 1'b1;
            bytes_sent++;
            if (char_idx >= 7'd66) begin
                r.slast  = 1'b1;
                tx_busy  = 1'b0;
                char_idx = '0;
                sentences_done++;
            end else begin
                char_idx = char_idx + 1'b1;
            end
        end
        r.pulse_fast = high_phase;
        r.pulse_slow = slow_lvl;
        r.hour       = hh;
        r.minute     = mm;
        r.second     = ss;
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // tick driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            tick_if.valid = 1'b0;
            gap_left      = 0;
        end else if (ticks_taken == ticks_issued) begin
            if (gap_left != 0) begin
                tick_if.valid = 1'b0;
                gap_left--;
            end else if (pending_ticks.size() != 0) begin
                tick_if.valid      = 1'b1;
                tick_if.byte_ready = pending_ticks.pop_front();
                ticks_issued++;
                gap_left = pick_gap();
            end else begin
                tick_if.valid = 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready = 1'b0;
            stall_left   = 0;
        end else if (stall_left != 0) begin
            out_if.ready = 1'b0;
            stall_left--;
        end else begin
            out_if.ready = 1'b1;
            if ($urandom_range(0, 7) == 0) stall_left = pick_gap();
        end
    end

    always @(posedge i_clk) begin : monitor
        t_tick_result want;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                if (predicted_outputs.size() == 0) begin
                    report_mismatch("unexpected result item", 1, 0);
                end else begin
                    want = predicted_outputs.pop_front();
                    if (out_if.pulse_fast !== want.pulse_fast)
                        report_mismatch("pulse_fast", out_if.pulse_fast, want.pulse_fast);
                    if (out_if.pulse_slow !== want.pulse_slow)
                        report_mismatch("pulse_slow", out_if.pulse_slow, want.pulse_slow);
                    if (out_if.clock_hour !== want.hour)
                        report_mismatch("clock_hour", out_if.clock_hour, want.hour);
                    if (out_if.clock_minute !== want.minute)
                        report_mismatch("clock_minute", out_if.clock_minute, want.minute);
                    if (out_if.clock_second !== want.second)
                        report_mismatch("clock_second", out_if.clock_second, want.second);
                    if (out_if.sentence_byte !== want.sbyte)
                        report_mismatch("sentence_byte", out_if.sentence_byte, want.sbyte);
                    if (out_if.sentence_valid !== want.svalid)
                        report_mismatch("sentence_valid", out_if.sentence_valid, want.svalid);
                    if (out_if.sentence_last !== want.slast)
                        report_mismatch("sentence_last", out_if.sentence_last, want.slast);
                end
            end
            if (tick_if.valid && tick_if.ready) begin
                predicted_outputs.push_back(next_tick(tick_if.byte_ready));
                ticks_taken++;
            end
        end
    end

    task automatic wait_idle();
        while (pending_ticks.size() != 0 || ticks_taken != ticks_issued ||
               predicted_outputs.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        logic [CFG_DATA_W-1:0] want;
        wait_idle();
        want = (idx == REG_PPS) ? CFG_DATA_W'(value[PPS_W-1:0])
                                : CFG_DATA_W'(value[COUNT_BITS-1:0]);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            REG_PERIOD: m_period = value[COUNT_BITS-1:0];
            REG_WIDTH:  m_width  = value[COUNT_BITS-1:0];
            default:    m_pps    = value[PPS_W-1:0];
        endcase
        cfg_writes++;
        // read back
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        if (prdata !== want) report_mismatch("prdata", prdata, want);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_config(input logic [31:0] period, input logic [31:0] width,
                              input logic [31:0] pps);
        write_reg(REG_PERIOD, period);
        write_reg(REG_WIDTH, width);
        write_reg(REG_PPS, pps);
    endtask

    task automatic push_ticks(input int unsigned n, input int unsigned ready_pct);
        repeat (n) pending_ticks.push_back($urandom_range(0, 99) < ready_pct);
    endtask

    initial begin
        int unsigned period, width, pps;
        tick_if.valid      = 1'b0;
        tick_if.byte_ready = 1'b0;
        out_if.ready       = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        ticks_issued       = 0;
        ticks_taken        = 0;
        gap_left           = 0;
        stall_left         = 0;
        error_count        = 0;
        seconds_ticked     = 0;
        bytes_sent         = 0;
        sentences_done     = 0;
        cfg_writes         = 0;
        no_idle            = 1'b0;
        m_period           = COUNT_BITS'(100000);
        m_width            = COUNT_BITS'(1000);
        m_pps              = 4'd10;
        phase_cnt          = '0;
        fast_cnt           = '0;
        high_phase         = 1'b0;
        slow_lvl           = 1'b0;
        req_pending        = 1'b0;
        tx_busy            = 1'b0;
        hh                 = 5'd12;
        mm                 = '0;
        ss                 = '0;
        lat_h              = '0;
        lat_m              = '0;
        lat_s              = '0;
        char_idx           = '0;
        csum               = '0;
        i_rst_n            = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset settings, fastest timing, zero and oversized widths, extreme pps and period
        pending_ticks.push_back(1'b0);
        pending_ticks.push_back(1'b1);
        pending_ticks.push_back(1'b0);
        set_config(2, 1, 1);
        push_ticks(6, 100);
        write_reg(REG_WIDTH, 0);
        write_reg(REG_PPS, 0);
        repeat (2) begin
            pending_ticks.push_back(1'b1);
            pending_ticks.push_back(1'b0);
        end
        write_reg(REG_WIDTH, 20'hFFFFE);
        write_reg(REG_PPS, 15);
        push_ticks(4, 100);
        set_config(20'hFFFFF, 1, 15);
        push_ticks(5, 100);
        // shrinking the period leaves the phase counter past its new length
        write_reg(REG_PERIOD, 3);
        push_ticks(3, 100);

        // fast seconds across a minute boundary, with a full drain midway
        set_config(2, 1, 1);
        push_ticks(70, 100);
        wait_idle();
        push_ticks(70, 90);

        repeat (9) begin
            case ($urandom_range(0, 7))
                0: begin
                    period = $urandom_range(2, 20'hFFFFF);
                    width  = $urandom_range(1, 20'hFFFFE);
                end
                1: begin
                    period = $urandom_range(2, 4);
                    width  = $urandom_range(period, period + 3);
                end
                default: begin
                    period = $urandom_range(2, 12);
                    width  = $urandom_range(1, period - 1);
                end
            endcase
            pps = ($urandom_range(0, 9) < 6) ? $urandom_range(1, 3) : $urandom_range(1, 15);
            set_config(period, width, pps);
            no_idle = ($urandom_range(0, 3) == 0);
            push_ticks(130, ($urandom_range(0, 2) == 0) ? 100 : $urandom_range(40, 99));
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        $display("checked %0d ticks over %0d register writes", ticks_taken, cfg_writes);
        $display("clock advanced %0d seconds, %0d sentence bytes, %0d full sentences",
                 seconds_ticked, bytes_sent, sentences_done);
        if (error_count == 0) begin
            $display("[pps_pulse_and_gprmc_time_generator] OK");
        end else begin
            $display("[pps_pulse_and_gprmc_time_generator] ERROR");
        end
        $finish;
    end

    initial begin
        #9600000;
        $display("timeout after %0d of %0d ticks", ticks_taken, ticks_issued);
        $display("[pps_pulse_and_gprmc_time_generator] ERROR");
        $finish;
    end

endmodule
